// ----- rtl/core/arsl_pkg.sv -----
// Shared types and constants for the address range lookup block.
// No dependencies; RTL uses scoped names, verif files import it.
package arsl_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = IDX_W + 1;
  localparam int ADDR_W      = 64;
  localparam int OFS_W       = 32;
  localparam int CFG_IDX_W   = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_ADDRESS     = 3'd0,
    REG_ENTRY_COUNT      = 3'd1,
    REG_NAME_BYTES       = 3'd2,
    REG_HEADER_VALID     = 3'd3,
    REG_NAMES_TERMINATED = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    MODE_LOAD   = 1'b0,
    MODE_LOOKUP = 1'b1
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_SEARCH,
    ST_INFO,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [CNT_W-1:0]  count;       // already clamped to MAX_ENTRIES
    logic [OFS_W-1:0]  name_bytes;
    logic              header_valid;
    logic              names_terminated;
  } cfg_t;

  typedef struct packed {
    logic [OFS_W-1:0] size;
    logic [OFS_W-1:0] name_offset;
  } info_t;

  typedef struct packed {
    logic              hit;
    logic [IDX_W-1:0]  index;
    logic [OFS_W-1:0]  name_offset;
    logic [ADDR_W-1:0] region_start;
    logic [OFS_W-1:0]  region_offset;
  } result_t;

endpackage

// ----- rtl/core/arsl_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module arsl_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- rtl/core/arsl_ctrl.sv -----
// Lookup sequencer: base check, binary search over the start-offset RAM,
// final size/name check on the info RAM word. Uses arsl_pkg.
module arsl_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             mode_i,
  input  logic [arsl_pkg::ADDR_W-1:0]      address_i,
  output logic                             in_stall_o,
  input  arsl_pkg::cfg_t                   cfg_i,
  output logic [arsl_pkg::IDX_W-1:0]       start_raddr_o,
  input  logic [arsl_pkg::OFS_W-1:0]       start_rdata_i,
  output logic [arsl_pkg::IDX_W-1:0]       info_raddr_o,
  input  arsl_pkg::info_t                  info_rdata_i,
  input  logic                             out_free_i,
  output logic                             res_load_o,
  output arsl_pkg::result_t                res_o
);

  arsl_pkg::state_e state_q, state_d;

  logic [arsl_pkg::OFS_W-1:0] w32_q, w32_d;
  logic                       premiss_q, premiss_d;
  logic [arsl_pkg::IDX_W-1:0] lo_q, lo_d;
  logic [arsl_pkg::CNT_W-1:0] hi_q, hi_d;
  logic [arsl_pkg::IDX_W-1:0] mid_q, mid_d;
  logic [arsl_pkg::OFS_W-1:0] start_lo_q, start_lo_d;
  arsl_pkg::result_t          res_q, res_d;

  logic                       lookup_acc;
  logic [arsl_pkg::ADDR_W:0]  diff;
  logic                       premiss_in;
  logic                       cmp_le;
  logic                       first_miss;
  logic [arsl_pkg::OFS_W-1:0] delta;
  logic                       range_miss;
  logic [arsl_pkg::CNT_W-1:0] span_d;
  logic [arsl_pkg::CNT_W-1:0] mid_sum;
  logic                       more_d;

  assign lookup_acc = (state_q == arsl_pkg::ST_IDLE) && in_valid_i
                      && (mode_i == arsl_pkg::MODE_LOOKUP);

  // borrow out of the 65-bit subtract means address below base
  assign diff = {1'b0, address_i} - {1'b0, cfg_i.base};
  assign premiss_in = !cfg_i.header_valid || !cfg_i.names_terminated
                      || (cfg_i.count == '0) || diff[arsl_pkg::ADDR_W]
                      || (diff[arsl_pkg::ADDR_W-1:arsl_pkg::OFS_W] != '0);

  assign cmp_le     = (start_rdata_i <= w32_q);
  assign first_miss = premiss_q || (w32_q < start_rdata_i);

  assign delta      = w32_q - start_lo_q;
  assign range_miss = ((info_rdata_i.size != '0) && (delta >= info_rdata_i.size))
                      || (info_rdata_i.name_offset >= cfg_i.name_bytes);

  // next probe point from the updated bounds
  assign span_d  = hi_d - {1'b0, lo_d};
  assign mid_sum = {1'b0, lo_d} + (span_d >> 1);
  assign more_d  = (span_d > arsl_pkg::CNT_W'(1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      arsl_pkg::ST_IDLE: begin
        if (lookup_acc) state_d = arsl_pkg::ST_FIRST;
      end
      arsl_pkg::ST_FIRST: begin
        if (first_miss)  state_d = arsl_pkg::ST_DONE;
        else if (more_d) state_d = arsl_pkg::ST_SEARCH;
        else             state_d = arsl_pkg::ST_INFO;
      end
      arsl_pkg::ST_SEARCH: begin
        if (!more_d) state_d = arsl_pkg::ST_INFO;
      end
      arsl_pkg::ST_INFO: begin
        state_d = arsl_pkg::ST_DONE;
      end
      arsl_pkg::ST_DONE: begin
        if (out_free_i) state_d = arsl_pkg::ST_IDLE;
      end
      default: state_d = arsl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    w32_d      = w32_q;
    premiss_d  = premiss_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    start_lo_d = start_lo_q;
    res_d      = res_q;
    res_load_o = 1'b0;
    unique case (state_q)
      arsl_pkg::ST_IDLE: begin
        if (lookup_acc) begin
          w32_d     = diff[arsl_pkg::OFS_W-1:0];
          premiss_d = premiss_in;
          lo_d      = '0;
          hi_d      = cfg_i.count;
        end
      end
      arsl_pkg::ST_FIRST: begin
        if (first_miss) res_d = '0;
        else            start_lo_d = start_rdata_i;
      end
      arsl_pkg::ST_SEARCH: begin
        if (cmp_le) begin
          lo_d       = mid_q;
          start_lo_d = start_rdata_i;
        end else begin
          hi_d = {1'b0, mid_q};
        end
      end
      arsl_pkg::ST_INFO: begin
        if (range_miss) begin
          res_d = '0;
        end else begin
          res_d.hit           = 1'b1;
          res_d.index         = lo_q;
          res_d.name_offset   = info_rdata_i.name_offset;
          res_d.region_start  = cfg_i.base + {{(arsl_pkg::ADDR_W-arsl_pkg::OFS_W){1'b0}},
                                              start_lo_q};
          res_d.region_offset = delta;
        end
      end
      arsl_pkg::ST_DONE: begin
        res_load_o = out_free_i;
      end
      default: ;
    endcase
  end

  // entry 0 is probed on accept; afterwards the midpoint of the new bounds
  assign start_raddr_o = (state_q == arsl_pkg::ST_IDLE) ? '0
                         : mid_sum[arsl_pkg::IDX_W-1:0];
  assign mid_d         = start_raddr_o;
  assign info_raddr_o  = lo_d;
  assign in_stall_o    = (state_q != arsl_pkg::ST_IDLE);
  assign res_o         = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= arsl_pkg::ST_IDLE;
      lo_q    <= '0;
      hi_q    <= '0;
    end else begin
      state_q <= state_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w32_q      <= w32_d;
    premiss_q  <= premiss_d;
    mid_q      <= mid_d;
    start_lo_q <= start_lo_d;
    res_q      <= res_d;
  end

endmodule

// ----- rtl/core/address_range_symbol_lookup.sv -----
// Top level of the address range lookup: config registers, region RAMs,
// output register. Depends on arsl_pkg, arsl_ram, arsl_ctrl.
//
//  channel | direction | handshake               | word
//  --------+-----------+-------------------------+---------------------------------
//  in      | sink      | in_valid_i / in_stall_o | mode, entry fields, address
//  out     | source    | out_valid_o/out_stall_i | hit, index, name, start, offset
//  cfg     | sink      | cfg_valid_i/cfg_ready_o | register index, 64-bit data
//
// Loads write both RAMs at the accept edge and leave the sequencer idle. A
// lookup steps through the entry 0 probe, one start-RAM read per search
// step, the info read and the output load; early misses go straight from
// the entry 0 probe to the output load.
// Reset clears sequencer, config and output valid; RAMs are undefined until
// loaded. A stalled result waits in the output register while the next word is taken.
module address_range_symbol_lookup (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input words
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                mode_i,
  input  logic [arsl_pkg::IDX_W-1:0]          entry_index_i,
  input  logic [arsl_pkg::OFS_W-1:0]          entry_offset_i,
  input  logic [arsl_pkg::OFS_W-1:0]          entry_size_i,
  input  logic [arsl_pkg::OFS_W-1:0]          entry_name_offset_i,
  input  logic [arsl_pkg::ADDR_W-1:0]         address_i,
  // result words
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                hit_o,
  output logic [arsl_pkg::IDX_W-1:0]          hit_index_o,
  output logic [arsl_pkg::OFS_W-1:0]          name_offset_o,
  output logic [arsl_pkg::ADDR_W-1:0]         region_start_o,
  output logic [arsl_pkg::OFS_W-1:0]          region_offset_o,
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [arsl_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [arsl_pkg::ADDR_W-1:0]         cfg_data_i
);

  // ---------------------------------------------------------------------
  // Configuration registers (always ready; unknown indexes are dropped)
  // ---------------------------------------------------------------------
  logic [arsl_pkg::ADDR_W-1:0] base_q;
  logic [arsl_pkg::CNT_W-1:0]  entry_count_q;
  logic [arsl_pkg::OFS_W-1:0]  name_bytes_q;
  logic                        header_valid_q;
  logic                        names_terminated_q;
  logic                        cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q             <= '0;
      entry_count_q      <= '0;
      name_bytes_q       <= '0;
      header_valid_q     <= 1'b0;
      names_terminated_q <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        arsl_pkg::REG_BASE_ADDRESS:     base_q <= cfg_data_i;
        arsl_pkg::REG_ENTRY_COUNT:      entry_count_q <= cfg_data_i[arsl_pkg::CNT_W-1:0];
        arsl_pkg::REG_NAME_BYTES:       name_bytes_q <= cfg_data_i[arsl_pkg::OFS_W-1:0];
        arsl_pkg::REG_HEADER_VALID:     header_valid_q <= cfg_data_i[0];
        arsl_pkg::REG_NAMES_TERMINATED: names_terminated_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  arsl_pkg::cfg_t cfg;

  // counts past the table size search the whole table
  assign cfg.base  = base_q;
  assign cfg.count = (entry_count_q > arsl_pkg::CNT_W'(arsl_pkg::MAX_ENTRIES))
                     ? arsl_pkg::CNT_W'(arsl_pkg::MAX_ENTRIES) : entry_count_q;
  assign cfg.name_bytes       = name_bytes_q;
  assign cfg.header_valid     = header_valid_q;
  assign cfg.names_terminated = names_terminated_q;

  // ---------------------------------------------------------------------
  // Region RAMs: start offsets are probed by the search, size and name
  // offset are read once at the end. Loads are only taken while the
  // sequencer is idle, so a write never overlaps a search read.
  // ---------------------------------------------------------------------
  logic                       load_we;
  logic [arsl_pkg::IDX_W-1:0] start_raddr;
  logic [arsl_pkg::OFS_W-1:0] start_rdata;
  logic [arsl_pkg::IDX_W-1:0] info_raddr;
  arsl_pkg::info_t            info_wdata;
  arsl_pkg::info_t            info_rdata;

  assign load_we = in_valid_i && !in_stall_o && (mode_i == arsl_pkg::MODE_LOAD);
  assign info_wdata.size        = entry_size_i;
  assign info_wdata.name_offset = entry_name_offset_i;

  arsl_ram #(
    .Width (arsl_pkg::OFS_W),
    .Depth (arsl_pkg::MAX_ENTRIES)
  ) u_start_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (entry_index_i),
    .wdata_i (entry_offset_i),
    .raddr_i (start_raddr),
    .rdata_o (start_rdata)
  );

  arsl_ram #(
    .Width ($bits(arsl_pkg::info_t)),
    .Depth (arsl_pkg::MAX_ENTRIES)
  ) u_info_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (entry_index_i),
    .wdata_i (info_wdata),
    .raddr_i (info_raddr),
    .rdata_o (info_rdata)
  );

  // ---------------------------------------------------------------------
  // Search sequencer
  // ---------------------------------------------------------------------
  logic              out_free;
  logic              res_load;
  arsl_pkg::result_t res;

  arsl_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .mode_i        (mode_i),
    .address_i     (address_i),
    .in_stall_o    (in_stall_o),
    .cfg_i         (cfg),
    .start_raddr_o (start_raddr),
    .start_rdata_i (start_rdata),
    .info_raddr_o  (info_raddr),
    .info_rdata_i  (info_rdata),
    .out_free_i    (out_free),
    .res_load_o    (res_load),
    .res_o         (res)
  );

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  logic              out_valid_q, out_valid_d;
  arsl_pkg::result_t out_q;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load)         out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = out_q.hit;
  assign hit_index_o     = out_q.index;
  assign name_offset_o   = out_q.name_offset;
  assign region_start_o  = out_q.region_start;
  assign region_offset_o = out_q.region_offset;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> !(out_valid_q && out_stall_i))
    else $error("result loaded over a stalled output word");

  // a hit always names an entry inside the name area
  a_hit_name: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_load && res.hit) |-> (res.name_offset < name_bytes_q))
    else $error("hit with name offset past the name area");

  // a miss carries all-zero fields
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_load && !res.hit) |-> ((res.index == '0) && (res.name_offset == '0)
                                && (res.region_start == '0) && (res.region_offset == '0)))
    else $error("miss result with nonzero fields");

  // a lookup keeps the block busy and blocks loads on the next cycle
  a_lookup_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (mode_i == arsl_pkg::MODE_LOOKUP))
      |=> (in_stall_o && !load_we))
    else $error("sequencer not busy after a lookup was taken");

endmodule

// ----- verif/arsl_check_pkg.sv -----
`timescale 1ns / 100ps
// Scoreboard for the address range lookup testbench: a region table predictor
// and the queue of lookup results still owed. Depends on arsl_pkg.
package arsl_check_pkg;
  import arsl_pkg::*;

  class region_lookup_check;
    logic [OFS_W-1:0]  start_ofs [MAX_ENTRIES];
    logic [OFS_W-1:0]  size_tab  [MAX_ENTRIES];
    logic [OFS_W-1:0]  name_tab  [MAX_ENTRIES];
    logic [ADDR_W-1:0] base;
    logic [CNT_W-1:0]  count_reg;
    logic [OFS_W-1:0]  name_bytes;
    logic              header_ok;
    logic              names_ok;
    result_t           owed [$];
    int                errors;

    function new();
      base       = '0;
      count_reg  = '0;
      name_bytes = '0;
      header_ok  = 1'b0;
      names_ok   = 1'b0;
      errors     = 0;
      foreach (start_ofs[i]) begin
        start_ofs[i] = '0;
        size_tab[i]  = '0;
        name_tab[i]  = '0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
      case (idx)
        REG_BASE_ADDRESS:     base       = data;
        REG_ENTRY_COUNT:      count_reg  = data[CNT_W-1:0];
        REG_NAME_BYTES:       name_bytes = data[OFS_W-1:0];
        REG_HEADER_VALID:     header_ok  = data[0];
        REG_NAMES_TERMINATED: names_ok   = data[0];
        default: ;  // unmapped index, dropped
      endcase
    endfunction

    // count register clamps at the table depth
    function int unsigned active_entries();
      return (count_reg > CNT_W'(MAX_ENTRIES)) ? 32'(MAX_ENTRIES) : 32'(count_reg);
    endfunction

    function result_t resolve(logic [ADDR_W-1:0] addr);
      result_t           r;
      logic [ADDR_W-1:0] span;
      logic [OFS_W-1:0]  w, delta;
      int unsigned       n, lo, hi, mid;
      r = '0;
      n = active_entries();
      if (!header_ok || !names_ok || n == 0 || addr < base) return r;
      span = addr - base;
      if (span > {32'h0, {OFS_W{1'b1}}}) return r;
      w = span[OFS_W-1:0];
      if (w < start_ofs[0]) return r;
      lo = 0;
      hi = n;
      while (hi - lo > 1) begin
        mid = lo + (hi - lo) / 2;
        if (start_ofs[mid] <= w) lo = mid;
        else hi = mid;
      end
      delta = w - start_ofs[lo];
      if ((size_tab[lo] != '0 && delta >= size_tab[lo]) || name_tab[lo] >= name_bytes)
        return r;
      r.hit           = 1'b1;
      r.index         = IDX_W'(lo);
      r.name_offset   = name_tab[lo];
      r.region_start  = base + {32'h0, start_ofs[lo]};
      r.region_offset = delta;
      return r;
    endfunction

    function void note_word(mode_e mode, logic [IDX_W-1:0] slot, logic [OFS_W-1:0] ofs,
                            logic [OFS_W-1:0] len, logic [OFS_W-1:0] noff,
                            logic [ADDR_W-1:0] addr);
      if (mode == MODE_LOAD) begin
        start_ofs[slot] = ofs;
        size_tab[slot]  = len;
        name_tab[slot]  = noff;
      end else begin
        owed.push_back(resolve(addr));
      end
    endfunction

    function void mismatch(string field, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
      if (errors < 40)
        $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
      errors++;
    endfunction

    function void check_result(result_t seen);
      result_t due;
      if (owed.size() == 0) begin
        if (errors < 40)
          $display("%0t: result word with none outstanding, expected none, got %h",
                   $time, seen);
        errors++;
        return;
      end
      due = owed.pop_front();
      if (seen.hit !== due.hit)
        mismatch("hit", ADDR_W'(due.hit), ADDR_W'(seen.hit));
      if (seen.index !== due.index)
        mismatch("hit_index", ADDR_W'(due.index), ADDR_W'(seen.index));
      if (seen.name_offset !== due.name_offset)
        mismatch("name_offset", ADDR_W'(due.name_offset), ADDR_W'(seen.name_offset));
      if (seen.region_start !== due.region_start)
        mismatch("region_start", due.region_start, seen.region_start);
      if (seen.region_offset !== due.region_offset)
        mismatch("region_offset", ADDR_W'(due.region_offset), ADDR_W'(seen.region_offset));
    endfunction
  endclass

endpackage

// ----- verif/address_range_symbol_lookup_tb.sv -----
`timescale 1ns / 100ps
// Testbench for address_range_symbol_lookup: directed and random load and lookup
// words with random idling, checked against arsl_check_pkg. Needs arsl_pkg and the RTL.
module address_range_symbol_lookup_tb;
  import arsl_pkg::*;
  import arsl_check_pkg::*;

  localparam int RANDOM_WORDS   = 600;
  localparam int HOLD_OFF       = 24;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 4000;  // cycles without any handshake
  localparam int GUARD_FROM     = 16;    // real entries below the first guard slot

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LAST  = 3'd7;
  localparam logic [OFS_W-1:0]     OFS_MAX  = '1;
  localparam logic [ADDR_W-1:0]    ADDR_MAX = '1;
  localparam logic [CNT_W-1:0]     COUNT_MAX = '1;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_style_e;

  logic                 clk_i               = 1'b0;
  logic                 rst_ni              = 1'b0;
  logic                 in_valid_i          = 1'b0;
  logic                 in_stall_o;
  logic                 mode_i              = MODE_LOAD;
  logic [IDX_W-1:0]     entry_index_i       = '0;
  logic [OFS_W-1:0]     entry_offset_i      = '0;
  logic [OFS_W-1:0]     entry_size_i        = '0;
  logic [OFS_W-1:0]     entry_name_offset_i = '0;
  logic [ADDR_W-1:0]    address_i           = '0;
  logic                 out_valid_o;
  logic                 out_stall_i         = 1'b0;
  logic                 hit_o;
  logic [IDX_W-1:0]     hit_index_o;
  logic [OFS_W-1:0]     name_offset_o;
  logic [ADDR_W-1:0]    region_start_o;
  logic [OFS_W-1:0]     region_offset_o;
  logic                 cfg_valid_i         = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i         = '0;
  logic [ADDR_W-1:0]    cfg_data_i          = '0;

  region_lookup_check board = new();

  address_range_symbol_lookup DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .mode_i              (mode_i),
    .entry_index_i       (entry_index_i),
    .entry_offset_i      (entry_offset_i),
    .entry_size_i        (entry_size_i),
    .entry_name_offset_i (entry_name_offset_i),
    .address_i           (address_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .hit_o               (hit_o),
    .hit_index_o         (hit_index_o),
    .name_offset_o       (name_offset_o),
    .region_start_o      (region_start_o),
    .region_offset_o     (region_offset_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Port monitor. Everything is sampled at the rising edge, before the
  // nonblocking updates of that edge land, so handshakes are seen exactly as
  // the block sees them. Results are checked before new words are noted.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch_ports
    result_t seen;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        seen = {hit_o, hit_index_o, name_offset_o, region_start_o, region_offset_o};
        board.check_result(seen);
      end
      if (in_valid_i && !in_stall_o)
        board.note_word(mode_e'(mode_i), entry_index_i, entry_offset_i, entry_size_i,
                        entry_name_offset_i, address_i);
      if (cfg_valid_i && cfg_ready_o)
        board.write_reg(cfg_index_i, cfg_data_i);
    end
  end

  // ---------------------------------------------------------------------------
  // Result-side backpressure: the style is redrawn at random among no stall,
  // light and heavy random stall, and a fixed periodic pattern.
  // ---------------------------------------------------------------------------
  stall_style_e stall_style = STALL_NONE;
  int           stall_left  = 0;
  int unsigned  cyc         = 0;

  always @(posedge clk_i) begin
    cyc++;
    if (stall_left == 0) begin
      stall_style = stall_style_e'($urandom_range(0, 3));
      stall_left  = int'($urandom_range(16, 160));
    end else begin
      stall_left--;
    end
    case (stall_style)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:     out_stall_i <= ((cyc % 8) < 5);
    endcase
  end

  // Watchdog: any handshake on any channel restarts the count.
  int quiet = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet = 0;
    else
      quiet++;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side. Words go out in bursts; between bursts valid drops for a
  // random gap. Inside a burst valid stays high from word to word, and the
  // payload only moves after the edge that took it.
  // ---------------------------------------------------------------------------
  int burst_left   = 0;
  int random_words = 0;

  function automatic logic [ADDR_W-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic send_word(mode_e mode, logic [IDX_W-1:0] slot, logic [OFS_W-1:0] ofs,
                           logic [OFS_W-1:0] len, logic [OFS_W-1:0] noff,
                           logic [ADDR_W-1:0] addr);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      // one burst in four is long enough to run with no idling at all
      burst_left = ($urandom_range(0, 3) == 0) ? int'($urandom_range(40, 120))
                                                : int'($urandom_range(1, 12));
    end
    burst_left--;
    mode_i              <= mode;
    entry_index_i       <= slot;
    entry_offset_i      <= ofs;
    entry_size_i        <= len;
    entry_name_offset_i <= noff;
    address_i           <= addr;
    in_valid_i          <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // load words carry a random address and lookups random entry fields, so
  // the unused fields toggle too
  task automatic send_load(int unsigned slot, logic [OFS_W-1:0] ofs, logic [OFS_W-1:0] len,
                           logic [OFS_W-1:0] noff);
    send_word(MODE_LOAD, IDX_W'(slot), ofs, len, noff, rand64());
  endtask

  task automatic send_lookup(logic [ADDR_W-1:0] addr);
    send_word(MODE_LOOKUP, IDX_W'($urandom()), $urandom(), $urandom(), $urandom(), addr);
  endtask

  // Drop valid, wait for every owed result, then idle for hold cycles.
  // Always crosses at least one edge so valid is never lowered and raised
  // in the same step.
  task automatic settle(int hold);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.owed.size() != 0);
    repeat (hold) @(posedge clk_i);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Registers only change with the block idle; sometimes an unmapped index
  // is written first, which must change nothing.
  task automatic configure(logic [ADDR_W-1:0] base, logic [CNT_W-1:0] count,
                           logic [OFS_W-1:0] nb, logic hv, logic nt);
    settle(HOLD_OFF);
    if ($urandom_range(0, 3) == 0)
      put_reg(CFG_IDX_W'($urandom_range(REG_UNMAPPED_FIRST, REG_UNMAPPED_LAST)), rand64());
    put_reg(REG_BASE_ADDRESS, base);
    put_reg(REG_ENTRY_COUNT, {{(ADDR_W-CNT_W){1'b0}}, count});
    put_reg(REG_NAME_BYTES, {32'h0, nb});
    put_reg(REG_HEADER_VALID, {63'h0, hv});
    put_reg(REG_NAMES_TERMINATED, {63'h0, nt});
    cfg_valid_i <= 1'b0;
  endtask

  // Loads slots 0..n-1 with ascending starts (equal neighbours now and then),
  // sizes from zero (unbounded) to full range, and name offsets mostly inside
  // the name area of nb bytes.
  task automatic load_table(int unsigned n, logic [OFS_W-1:0] nb);
    logic [ADDR_W-1:0] pos;
    logic [OFS_W-1:0]  stride, len, noff;
    int unsigned       i;
    stride = OFS_MAX / n;
    pos = ($urandom_range(0, 2) == 0) ? '0 : {32'h0, $urandom_range(1, stride)};
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 4))
        0:       len = '0;
        1:       len = $urandom_range(1, 16);
        2:       len = $urandom();
        default: len = $urandom_range(1, stride);
      endcase
      if (nb == '0 || $urandom_range(0, 7) == 0)
        noff = $urandom_range(nb, OFS_MAX);
      else
        noff = $urandom_range(0, nb - 1'b1);
      send_load(i, pos[OFS_W-1:0], len, noff);
      case ($urandom_range(0, 9))
        0:       ;  // same start as the previous entry
        1:       pos = pos + {32'h0, $urandom_range(1, 16)};
        default: pos = pos + {32'h0, $urandom_range(1, stride)};
      endcase
      if (pos > {32'h0, OFS_MAX}) pos = {32'h0, OFS_MAX};
    end
  endtask

  // Lookup address aimed at the first n slots: region starts, last bytes,
  // one past the end, one below, inside, anywhere in the window, its top
  // byte or past the 32-bit window, and below the base.
  function automatic logic [ADDR_W-1:0] pick_address(int unsigned n);
    int unsigned       i;
    logic [ADDR_W-1:0] s, z, w;
    i = (n == 0) ? 0 : $urandom_range(0, n - 1);
    s = {32'h0, board.start_ofs[i]};
    z = {32'h0, board.size_tab[i]};
    case ($urandom_range(0, 7))
      0: w = s;
      1: w = s + z - 64'd1;
      2: w = s + z;
      3: w = s - 64'd1;
      4: w = s + ((z == '0) ? {32'h0, $urandom()}
                            : {32'h0, $urandom_range(0, z[OFS_W-1:0] - 1'b1)});
      5: w = {32'h0, $urandom()};
      6: return board.base - 64'd1 - {32'h0, $urandom_range(0, 255)};
      default: w = ($urandom_range(0, 1) == 0) ? {32'h0, OFS_MAX}
                                               : 64'h1_0000_0000 + {32'h0, $urandom()};
    endcase
    return board.base + w;
  endfunction

  // Keeps a lookup off the guard start value, so a search over the whole
  // depth always walks down the guard slots into the loaded entries.
  function automatic logic [ADDR_W-1:0] below_guard(logic [ADDR_W-1:0] addr);
    if (addr - board.base == {32'h0, OFS_MAX}) return addr - 64'd1;
    return addr;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [ADDR_W-1:0] dbase, base;
    logic [CNT_W-1:0]  count;
    logic [OFS_W-1:0]  nb;
    logic              hv, nt;
    int unsigned       g;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: a gap below the first region, a 16-byte region, an
    // unbounded one, one whose name lies past the name area, and one that
    // runs to the top of the 32-bit window. The last slot gets all ones.
    dbase = 64'h0000_1234_5678_0000;
    send_load(0, 32'h100, 32'h10, 32'h0);
    send_load(1, 32'h1000, 32'h0, 32'h5);
    send_load(2, 32'h2000, OFS_MAX, 32'h40);
    send_load(3, 32'hFFFF_FFF0, 32'h10, 32'h3F);
    send_load(MAX_ENTRIES - 1, OFS_MAX, OFS_MAX, OFS_MAX);
    send_lookup(dbase + 64'h100);              // registers at reset: miss

    configure(dbase, CNT_W'(4), 32'h40, 1'b1, 1'b1);
    send_lookup(dbase - 64'd1);                // below base
    send_lookup(dbase + 64'hFF);               // below the first start
    send_lookup(dbase + 64'h100);              // first byte of entry 0
    send_lookup(dbase + 64'h10F);              // last byte of entry 0
    send_lookup(dbase + 64'h110);              // just past entry 0
    send_lookup(dbase + 64'h1000 + 64'h123);   // unbounded entry
    send_lookup(dbase + 64'h1FFF);
    send_lookup(dbase + 64'h2000);             // name offset == name_bytes
    send_lookup(dbase + {32'h0, OFS_MAX});     // top of window, entry 3
    send_lookup(dbase + 64'h1_0000_0000);      // one past the window
    send_lookup(ADDR_MAX);
    send_lookup('0);

    // each table flag alone, then an empty table, all make a hit miss
    configure(dbase, CNT_W'(4), 32'h40, 1'b0, 1'b1);
    send_lookup(dbase + 64'h100);
    configure(dbase, CNT_W'(4), 32'h40, 1'b1, 1'b0);
    send_lookup(dbase + 64'h100);
    configure(dbase, CNT_W'(0), 32'h40, 1'b1, 1'b1);
    send_lookup(dbase + 64'h100);

    // Whole-depth search: a few real entries, then a top-of-window guard in
    // every power-of-two slot above them, so each probe lands on a loaded
    // slot. Then the count register at its maximum, which clamps to the
    // table depth.
    configure(rand64(), CNT_W'(MAX_ENTRIES), OFS_MAX, 1'b1, 1'b1);
    load_table(GUARD_FROM, OFS_MAX);
    for (g = GUARD_FROM; g < MAX_ENTRIES; g = g * 2)
      send_load(g, OFS_MAX, $urandom(), $urandom());
    repeat (40) send_lookup(below_guard(pick_address(GUARD_FROM)));
    configure(board.base, COUNT_MAX, $urandom(), 1'b1, 1'b1);
    repeat (20) send_lookup(below_guard(pick_address(GUARD_FROM)));

    // Random phases: new settings, a fresh small table, then lookups with
    // an occasional stray load, full-range address or full drain mixed in.
    while (random_words < RANDOM_WORDS) begin
      case ($urandom_range(0, 4))
        0:       base = '0;
        1:       base = ADDR_MAX;
        2:       base = rand64();
        3:       base = {32'h0, $urandom()};
        default: base = {32'hFFFF_FFFF, $urandom()};  // start + offset can wrap
      endcase
      case ($urandom_range(0, 9))
        0:       nb = '0;
        1:       nb = OFS_MAX;
        default: nb = $urandom();
      endcase
      hv = ($urandom_range(0, 7) != 0);
      nt = ($urandom_range(0, 7) != 0);
      case ($urandom_range(0, 10))
        0:       count = CNT_W'(1);
        1:       count = CNT_W'(0);
        2:       count = CNT_W'($urandom_range(17, 64));
        default: count = CNT_W'($urandom_range(2, 16));
      endcase
      configure(base, count, nb, hv, nt);
      if (count != 0 && count < CNT_W'(MAX_ENTRIES)) begin
        load_table(32'(count), nb);
        random_words += int'(count);
      end
      repeat ($urandom_range(8, 30)) begin
        case ($urandom_range(0, 19))
          0:       send_load($urandom_range(0, MAX_ENTRIES - 1), $urandom(), $urandom(),
                             $urandom());
          1:       settle(0);
          2:       send_lookup(rand64());
          default: send_lookup(pick_address(board.active_entries()));
        endcase
        random_words++;
      end
    end

    settle(DRAIN_CYCLES);
    if (board.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
